// File: rtl/dfb_pkg.sv
// Shared constants and types of the duplicate filter broadcaster.
`default_nettype none

package dfb_pkg;

    // Parameter defaults
    localparam int DEF_CACHE_ENTRIES = 256;
    localparam int DEF_MAX_NODES     = 16;
    localparam int DEF_KEY_WORDS     = 4;

    // Fixed field widths
    localparam int PORT_W   = 4;
    localparam int SENDER_W = 8;
    localparam int ID_W     = 16;
    localparam int HASH_W   = 64;
    localparam int NODE_W   = 5;
    localparam int DEST_W   = 4;

    // Node count after reset
    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(1);

    // Job queue between filter and broadcaster
    localparam int QUEUE_DEPTH = 2;

    // One broadcast job: what the back end needs to fan out a request
    typedef struct packed {
        logic [ID_W-1:0]   miner;
        logic [ID_W-1:0]   handle;
        logic [NODE_W-1:0] nodes;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/duplicate_filter_broadcaster_core.sv
// Top level of the duplicate filter broadcaster.
// Each request is checked (sender must be a non-negative node index below the
// node count, equal to the arrival port, and parsed). A request that passes
// is looked up in a ring cache of CACHE_ENTRIES hashes, one stored entry per
// cycle through the cache's single read port; the scan covers only the valid
// entries (at most CACHE_ENTRIES) and is skipped while the cache is empty, a
// duplicate ends it at the match, and a request dropped by the checks is not
// looked up at all. The front end also waits while the job queue is full. A new
// hash is written over the oldest entry; a request with an empty payload ends
// there. Otherwise a job goes through a two-entry queue to the broadcaster,
// which sends one copy per node, one per cycle while the receiver is ready, the
// last one flagged; it works while the front end scans the next request. The
// cache needs no clearing pass: a fill count limits the scan to written entries.
// node_count is written through cfg_we/cfg_wdata; the user must write it only
// while no request is in flight, the block itself does not enforce it.
`default_nettype none

module duplicate_filter_broadcaster_core
    import dfb_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int MAX_NODES     = DEF_MAX_NODES,
    parameter int KEY_WORDS     = DEF_KEY_WORDS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [NODE_W-1:0]          cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [PORT_W-1:0]          source_port,
    input  wire logic signed [SENDER_W-1:0] claimed_sender,
    input  wire logic                       parse_ok,
    input  wire logic                       payload_empty,
    input  wire logic [ID_W-1:0]            block_miner,
    input  wire logic [ID_W-1:0]            payload_handle,
    input  wire logic [HASH_W-1:0]          hash_word0,
    input  wire logic [HASH_W-1:0]          hash_word1,
    input  wire logic [HASH_W-1:0]          hash_word2,
    input  wire logic [HASH_W-1:0]          hash_word3,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [DEST_W-1:0]               dest_node,
    output logic [ID_W-1:0]                 forwarded_miner,
    output logic [ID_W-1:0]                 forwarded_payload,
    output logic                            last_copy
);

    logic              push_valid;
    logic              push_ready;
    job_t              push_data;
    logic              job_valid;
    logic              job_ready;
    job_t              job_data;
    logic [4*HASH_W-1:0] key_full;

    assign key_full = {hash_word3, hash_word2, hash_word1, hash_word0};

    // Checks and hash cache
    dfb_front #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .MAX_NODES     (MAX_NODES),
        .KEY_WORDS     (KEY_WORDS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .source_port    (source_port),
        .claimed_sender (claimed_sender),
        .parse_ok       (parse_ok),
        .payload_empty  (payload_empty),
        .block_miner    (block_miner),
        .payload_handle (payload_handle),
        .key_in         (key_full),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    // Job queue
    dfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_data   (job_data)
    );

    // Broadcaster
    dfb_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .job_valid         (job_valid),
        .job_ready         (job_ready),
        .job_data          (job_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .dest_node         (dest_node),
        .forwarded_miner   (forwarded_miner),
        .forwarded_payload (forwarded_payload),
        .last_copy         (last_copy)
    );

endmodule

`default_nettype wire

// File: rtl/dfb_front.sv
// Front end: request checks, hash cache scan and insert, job hand-off.
`default_nettype none

module dfb_front
    import dfb_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int MAX_NODES     = DEF_MAX_NODES,
    parameter int KEY_WORDS     = DEF_KEY_WORDS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [NODE_W-1:0]          cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [PORT_W-1:0]          source_port,
    input  wire logic signed [SENDER_W-1:0] claimed_sender,
    input  wire logic                       parse_ok,
    input  wire logic                       payload_empty,
    input  wire logic [ID_W-1:0]            block_miner,
    input  wire logic [ID_W-1:0]            payload_handle,
    input  wire logic [4*HASH_W-1:0]        key_in,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output job_t                            push_data
);

    localparam int KW = KEY_WORDS * HASH_W;
    localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int FW = $clog2(CACHE_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [NODE_W-1:0] node_count_reg;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [FW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [KW-1:0]     key_reg;
    logic              empty_reg;
    job_t              job_reg;
    logic [KW-1:0]     mem [CACHE_ENTRIES];
    logic [KW-1:0]     rd_data_reg;

    logic [NODE_W-1:0] nodes_eff;
    logic              req_ok;
    logic              accept;
    logic              rd_en;
    logic              hit;
    logic              mem_we;

    // Node count clamped to the supported maximum
    always_comb
    begin
        if (32'(node_count_reg) > MAX_NODES)
            nodes_eff = NODE_W'(MAX_NODES);
        else
            nodes_eff = node_count_reg;
    end

    // Sender must be a non-negative node index equal to the arrival port
    assign req_ok = !claimed_sender[SENDER_W-1]
                 && (SENDER_W'(claimed_sender) < SENDER_W'(nodes_eff))
                 && (SENDER_W'(claimed_sender) == SENDER_W'(source_port))
                 && parse_ok;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == ST_PUSH);
    assign push_data  = job_reg;

    // Scan: one cache read issued per cycle, its registered data compared in the next cycle
    assign rd_en  = (state_reg == ST_SCAN) && (idx_reg < fill_reg);
    assign hit    = pend_reg && (rd_data_reg == key_reg);
    assign mem_we = (state_reg == ST_INSERT);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_ok)
                begin
                    idx_next   = '0;
                    state_next = (fill_reg == '0) ? ST_INSERT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pend_next = rd_en;
                if (rd_en)
                    idx_next = idx_reg + FW'(1);
                if (hit)
                begin
                    state_next = ST_IDLE;
                    pend_next  = 1'b0;
                end
                else if (!rd_en && !pend_reg)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                // Ring write, oldest entry overwritten
                if (wp_reg == AW'(CACHE_ENTRIES - 1))
                    wp_next = '0;
                else
                    wp_next = wp_reg + AW'(1);
                if (fill_reg != FW'(CACHE_ENTRIES))
                    fill_next = fill_reg + FW'(1);
                state_next = empty_reg ? ST_IDLE : ST_PUSH;
            end
            ST_PUSH:
            begin
                if (push_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            fill_reg       <= '0;
            wp_reg         <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wp_reg    <= wp_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            if (cfg_we)
                node_count_reg <= cfg_wdata;
        end
    end

    // Captured request fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg        <= key_in[KW-1:0];
            empty_reg      <= payload_empty;
            job_reg.miner  <= block_miner;
            job_reg.handle <= payload_handle;
            job_reg.nodes  <= nodes_eff;
        end
    end

    // Hash cache
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= key_reg;
        if (rd_en)
            rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

endmodule

`default_nettype wire

// File: rtl/dfb_queue.sv
// Short job queue between the filter front end and the broadcaster.
`default_nettype none

module dfb_queue
    import dfb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: rtl/dfb_back.sv
// Back end: fans one job out into a copy per node through an output register.
`default_nettype none

module dfb_back
    import dfb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_valid,
    output logic              job_ready,
    input  wire job_t         job_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [DEST_W-1:0] dest_node,
    output logic [ID_W-1:0]   forwarded_miner,
    output logic [ID_W-1:0]   forwarded_payload,
    output logic              last_copy
);

    logic              active_reg;
    job_t              job_reg;
    logic [NODE_W-1:0] node_reg;
    logic              out_valid_reg;
    logic [DEST_W-1:0] dest_reg;
    logic [ID_W-1:0]   miner_reg;
    logic [ID_W-1:0]   payload_reg;
    logic              last_reg;
    logic              out_load;
    logic              is_last;

    assign job_ready = !active_reg;
    assign out_load  = active_reg && (!out_valid_reg || out_ready);
    assign is_last   = ((node_reg + NODE_W'(1)) == job_reg.nodes);

    assign out_valid         = out_valid_reg;
    assign dest_node         = dest_reg;
    assign forwarded_miner   = miner_reg;
    assign forwarded_payload = payload_reg;
    assign last_copy         = last_reg;

    // Job walk and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            node_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!active_reg && job_valid)
            begin
                active_reg <= 1'b1;
                node_reg   <= '0;
            end
            else if (out_load)
            begin
                if (is_last)
                    active_reg <= 1'b0;
                else
                    node_reg <= node_reg + NODE_W'(1);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Job capture and output payload
    always_ff @(posedge clk)
    begin
        if (!active_reg && job_valid)
            job_reg <= job_data;
        if (out_load)
        begin
            dest_reg    <= node_reg[DEST_W-1:0];
            miner_reg   <= job_reg.miner;
            payload_reg <= job_reg.handle;
            last_reg    <= is_last;
        end
    end

endmodule

`default_nettype wire

// File: dv/tb_duplicate_filter_broadcaster_core.sv
// Testbench for the duplicate filter broadcaster: directed and random requests, self-checked.
`timescale 1ns / 1ps

module tb_duplicate_filter_broadcaster_core;
    import dfb_pkg::*;

    // One offered request, as the sender sees it
    typedef struct packed {
        logic [PORT_W-1:0]      port;
        logic [SENDER_W-1:0]    sender;
        logic                   parse_ok;
        logic                   empty;
        logic [ID_W-1:0]        miner;
        logic [ID_W-1:0]        handle;
        logic [3:0][HASH_W-1:0] key;
    } block_t;

    // One forwarded copy
    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [ID_W-1:0]   miner;
        logic [ID_W-1:0]   handle;
        logic              last;
    } copy_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [NODE_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic [PORT_W-1:0] source_port;
    logic signed [SENDER_W-1:0] claimed_sender;
    logic parse_ok;
    logic payload_empty;
    logic [ID_W-1:0] block_miner;
    logic [ID_W-1:0] payload_handle;
    logic [HASH_W-1:0] hash_word0;
    logic [HASH_W-1:0] hash_word1;
    logic [HASH_W-1:0] hash_word2;
    logic [HASH_W-1:0] hash_word3;
    logic out_valid;
    logic out_ready;
    logic [DEST_W-1:0] dest_node;
    logic [ID_W-1:0] forwarded_miner;
    logic [ID_W-1:0] forwarded_payload;
    logic last_copy;

    // Predictor state: node count and the hash ring
    logic [NODE_W-1:0] node_cfg;
    logic [3:0][HASH_W-1:0] seen_key [DEF_CACHE_ENTRIES];
    int unsigned seen_fill;
    int unsigned seen_wp;

    copy_t copy_due [$];
    logic [3:0][HASH_W-1:0] key_log [$];
    int unsigned mismatch_count;
    bit calm;
    int unsigned hold_cycles;

    duplicate_filter_broadcaster_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .source_port       (source_port),
        .claimed_sender    (claimed_sender),
        .parse_ok          (parse_ok),
        .payload_empty     (payload_empty),
        .block_miner       (block_miner),
        .payload_handle    (payload_handle),
        .hash_word0        (hash_word0),
        .hash_word1        (hash_word1),
        .hash_word2        (hash_word2),
        .hash_word3        (hash_word3),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .dest_node         (dest_node),
        .forwarded_miner   (forwarded_miner),
        .forwarded_payload (forwarded_payload),
        .last_copy         (last_copy)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Node count as the block applies it (saturated at the node limit)
    function automatic int unsigned active_nodes();
        return (node_cfg > DEF_MAX_NODES) ? DEF_MAX_NODES : node_cfg;
    endfunction

    // Expected copies of one accepted request; updates the hash ring
    function automatic void predict_fanout(input block_t b);
        int unsigned nodes;
        bit match;
        copy_t c;
        nodes = active_nodes();
        if (b.sender[SENDER_W-1])
            return;
        if (b.sender >= nodes)
            return;
        if (b.sender != b.port)
            return;
        if (!b.parse_ok)
            return;
        for (int i = 0; i < seen_fill; i++)
        begin
            match = 1'b1;
            for (int w = 0; w < DEF_KEY_WORDS; w++)
                if (seen_key[i][w] != b.key[w])
                    match = 1'b0;
            if (match)
                return;
        end
        // new hash overwrites the oldest slot
        for (int w = 0; w < 4; w++)
            seen_key[seen_wp][w] = (w < DEF_KEY_WORDS) ? b.key[w] : '0;
        seen_wp = (seen_wp + 1) % DEF_CACHE_ENTRIES;
        if (seen_fill < DEF_CACHE_ENTRIES)
            seen_fill++;
        if (b.empty)
            return;
        for (int j = 0; j < nodes; j++)
        begin
            c.dest   = DEST_W'(j);
            c.miner  = b.miner;
            c.handle = b.handle;
            c.last   = (j + 1 == nodes);
            copy_due.push_back(c);
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [3:0][HASH_W-1:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic block_t make_block(input int unsigned port, input int sender,
                                          input bit ok, input bit empty,
                                          input logic [ID_W-1:0] miner,
                                          input logic [ID_W-1:0] handle,
                                          input logic [3:0][HASH_W-1:0] key);
        block_t b;
        b.port     = PORT_W'(port);
        b.sender   = SENDER_W'(sender);
        b.parse_ok = ok;
        b.empty    = empty;
        b.miner    = miner;
        b.handle   = handle;
        b.key      = key;
        return b;
    endfunction

    // Mostly well-formed requests; some repeat or nearly repeat an earlier hash
    function automatic block_t random_block();
        block_t b;
        int unsigned n;
        int unsigned pick;
        int unsigned w;
        int unsigned k;
        n = active_nodes();
        b.miner  = ID_W'($urandom);
        b.handle = ID_W'($urandom);
        pick = $urandom_range(0, 99);
        if (key_log.size() != 0 && pick < 8)
            b.key = key_log[$urandom_range(0, key_log.size() - 1)];
        else if (key_log.size() != 0 && pick < 12)
        begin
            b.key = key_log[$urandom_range(0, key_log.size() - 1)];
            w = $urandom_range(0, 3);
            k = $urandom_range(0, HASH_W - 1);
            b.key[w][k] = ~b.key[w][k];
        end
        else
            b.key = random_key();
        if (n != 0 && $urandom_range(0, 99) < 90)
        begin
            b.sender   = SENDER_W'($urandom_range(0, n - 1));
            b.port     = b.sender[PORT_W-1:0];
            b.parse_ok = 1'b1;
            b.empty    = ($urandom_range(0, 9) == 0);
        end
        else
        begin
            b.port     = PORT_W'($urandom);
            b.sender   = SENDER_W'($urandom);
            b.parse_ok = 1'($urandom);
            b.empty    = 1'($urandom);
        end
        key_log.push_back(b.key);
        return b;
    endfunction

    // Offer one request and hold it until accepted
    task automatic offer_block(input block_t b);
        int unsigned gap;
        bit rdy;
        gap = pick_idle();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        source_port    <= b.port;
        claimed_sender <= b.sender;
        parse_ok       <= b.parse_ok;
        payload_empty  <= b.empty;
        block_miner    <= b.miner;
        payload_handle <= b.handle;
        hash_word0     <= b.key[0];
        hash_word1     <= b.key[1];
        hash_word2     <= b.key[2];
        hash_word3     <= b.key[3];
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        predict_fanout(b);
    endtask

    // Wait for every copy, then for a full cache scan to finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (copy_due.size() != 0)
            @(posedge clk);
        repeat (DEF_CACHE_ENTRIES + 24) @(posedge clk);
    endtask

    task automatic set_node_count(input logic [NODE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        node_cfg = value;
    endtask

    // Default single node after reset
    task automatic test_reset_default();
        offer_block(make_block(0, 0, 1, 0, 16'hFFFF, 16'h0000, {4{64'hFFFF_FFFF_FFFF_FFFF}}));
        offer_block(make_block(0, 0, 1, 0, 16'h0000, 16'hFFFF, '0));
        offer_block(make_block(1, 1, 1, 0, 16'h1234, 16'h5678, random_key()));
    endtask

    // Sender must be a non-negative node index equal to the port, and parsed
    task automatic test_sender_checks();
        wait_idle();
        set_node_count(NODE_W'(DEF_MAX_NODES));
        offer_block(make_block(0, -128, 1, 0, 16'h0001, 16'h0002, random_key()));
        offer_block(make_block(15, -1, 1, 0, 16'h0003, 16'h0004, random_key()));
        offer_block(make_block(15, 127, 1, 0, 16'h0005, 16'h0006, random_key()));
        offer_block(make_block(0, 16, 1, 0, 16'h0007, 16'h0008, random_key()));
        offer_block(make_block(4, 3, 1, 0, 16'h0009, 16'h000A, random_key()));
        offer_block(make_block(5, 5, 0, 0, 16'h000B, 16'h000C, random_key()));
        offer_block(make_block(15, 15, 1, 0, 16'h0000, 16'hFFFF, random_key()));
        offer_block(make_block(0, 0, 1, 0, 16'hA5A5, 16'h5A5A, random_key()));
    endtask

    // Repeated hash dropped; a flip in the top or bottom word makes it new
    task automatic test_duplicate_keys();
        logic [3:0][HASH_W-1:0] k;
        logic [3:0][HASH_W-1:0] k_hi;
        logic [3:0][HASH_W-1:0] k_lo;
        k = random_key();
        k_hi = k;
        k_hi[3][HASH_W-1] = ~k_hi[3][HASH_W-1];
        k_lo = k;
        k_lo[0][0] = ~k_lo[0][0];
        offer_block(make_block(2, 2, 1, 0, 16'h1111, 16'h2222, k));
        offer_block(make_block(7, 7, 1, 0, 16'h3333, 16'h4444, k));
        offer_block(make_block(3, 3, 1, 0, 16'h5555, 16'h6666, k_hi));
        offer_block(make_block(9, 9, 1, 0, 16'h7777, 16'h8888, k_lo));
        offer_block(make_block(2, 2, 1, 0, 16'h9999, 16'hAAAA, k));
    endtask

    // Empty payload still records the hash
    task automatic test_empty_payload();
        logic [3:0][HASH_W-1:0] k;
        k = random_key();
        offer_block(make_block(1, 1, 1, 1, 16'hBBBB, 16'hCCCC, k));
        offer_block(make_block(1, 1, 1, 0, 16'hDDDD, 16'hEEEE, k));
        offer_block(make_block(6, 6, 1, 1, 16'hFFFE, 16'h0001, random_key()));
    endtask

    // Zero nodes drops everything; counts above the limit saturate
    task automatic test_node_count_limits();
        logic [3:0][HASH_W-1:0] k;
        k = random_key();
        wait_idle();
        set_node_count('0);
        offer_block(make_block(0, 0, 1, 0, 16'h0F0F, 16'hF0F0, k));
        wait_idle();
        set_node_count('1);
        offer_block(make_block(15, 15, 1, 0, 16'h0F0F, 16'hF0F0, k));
        offer_block(make_block(0, 0, 1, 0, 16'hC3C3, 16'h3C3C, random_key()));
        offer_block(make_block(8, 8, 1, 0, 16'h8000, 16'h0080, random_key()));
    endtask

    // Receiver holds off long enough for the input to stall
    task automatic test_output_backpressure();
        int unsigned s;
        wait_idle();
        set_node_count(NODE_W'(DEF_MAX_NODES));
        calm = 1'b1;
        hold_cycles = 400;
        repeat (8)
        begin
            s = $urandom_range(0, DEF_MAX_NODES - 1);
            offer_block(make_block(s, s, 1, 0, ID_W'($urandom), ID_W'($urandom),
                                   random_key()));
        end
        calm = 1'b0;
    endtask

    // Random requests over several node counts; enough new hashes to wrap the ring
    task automatic test_random_traffic();
        logic [NODE_W-1:0] setting [5];
        setting = '{NODE_W'(DEF_MAX_NODES), NODE_W'($urandom_range(2, 15)), NODE_W'(1),
                    NODE_W'($urandom_range(17, 31)), NODE_W'($urandom_range(1, 16))};
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            set_node_count(setting[p]);
            calm = (p == 1);
            repeat (64) offer_block(random_block());
        end
        calm = 1'b0;
    endtask

    // Receiver ready: random stalls plus a requested long hold-off
    initial
    begin
        int unsigned stall;
        out_ready <= 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else if (stall == 0 && !calm && $urandom_range(0, 3) == 0)
                stall = pick_idle();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Copy check: a handshake seen at the falling edge completes at the next rising edge
    always @(negedge clk)
    begin : copy_check
        copy_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (copy_due.size() == 0)
                flag_mismatch($sformatf("unexpected copy to node %0d", dest_node));
            else
            begin
                want = copy_due.pop_front();
                if (dest_node !== want.dest)
                    flag_mismatch($sformatf("dest_node %0d, want %0d", dest_node, want.dest));
                if (forwarded_miner !== want.miner)
                    flag_mismatch($sformatf("forwarded_miner %h, want %h",
                                            forwarded_miner, want.miner));
                if (forwarded_payload !== want.handle)
                    flag_mismatch($sformatf("forwarded_payload %h, want %h",
                                            forwarded_payload, want.handle));
                if (last_copy !== want.last)
                    flag_mismatch($sformatf("last_copy %b, want %b", last_copy, want.last));
            end
        end
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        in_valid       <= 1'b0;
        source_port    <= '0;
        claimed_sender <= '0;
        parse_ok       <= 1'b0;
        payload_empty  <= 1'b0;
        block_miner    <= '0;
        payload_handle <= '0;
        hash_word0     <= '0;
        hash_word1     <= '0;
        hash_word2     <= '0;
        hash_word3     <= '0;
        node_cfg = NODE_COUNT_RESET;
        seen_fill = 0;
        seen_wp = 0;
        mismatch_count = 0;
        calm = 1'b0;
        hold_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_default();
        test_sender_checks();
        test_duplicate_keys();
        test_empty_payload();
        test_node_count_limits();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
